@@ hdl/hrhp_pkg.sv @@
// Shared types, codes and character tables of the HTTP reply header parser.
`timescale 1ns / 1ps
`default_nettype none

package hrhp_pkg;

    // Result kinds
    localparam logic [1:0] KIND_BODY     = 2'd0;
    localparam logic [1:0] KIND_LOCATION = 2'd1;
    localparam logic [1:0] KIND_VERDICT  = 2'd2;

    // Verdict codes
    localparam logic [2:0] VERD_BODY_READY   = 3'd0;
    localparam logic [2:0] VERD_REDIRECT     = 3'd1;
    localparam logic [2:0] VERD_NO_STATUS    = 3'd2;
    localparam logic [2:0] VERD_MALFORMED    = 3'd3;
    localparam logic [2:0] VERD_NOT_OK       = 3'd4;
    localparam logic [2:0] VERD_UNTERMINATED = 3'd5;

    // Characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;

    localparam logic [3:0] PROTO_LEN    = 4'd5;
    localparam logic [3:0] KEY_LEN      = 4'd10;
    localparam logic [3:0] MATCH_FAILED = 4'd15;

    localparam logic [9:0] STATUS_OK      = 10'd200;
    localparam logic [9:0] STATUS_REDIR_LO = 10'd300;
    localparam logic [9:0] STATUS_REDIR_HI = 10'd400;
    localparam logic [9:0] STATUS_MAX     = 10'd999;

    // Queue between the parser and the result sequencer
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Everything one input beat produces, without the location length
    typedef struct packed {
        logic       cr_v;       // held CR goes out as a location byte
        logic       byte_v;     // data byte goes out
        logic [1:0] byte_kind;
        logic [7:0] data;
        logic       verd_v;     // verdict closes the reply
        logic [2:0] verdict;
        logic [9:0] status;
    } t_bundle;

    // "HTTP/"
    function automatic logic [7:0] proto_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h2F;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "location: " in lower case
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h6C;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h63;
            4'd3:    c = 8'h61;
            4'd4:    c = 8'h74;
            4'd5:    c = 8'h69;
            4'd6:    c = 8'h6F;
            4'd7:    c = 8'h6E;
            4'd8:    c = 8'h3A;
            4'd9:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/hrhp_if.sv @@
// Valid/ready channel interfaces for the byte input and the result output.
`timescale 1ns / 1ps
`default_nettype none

interface hrhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hrhp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  item_kind;
    logic [7:0]  out_byte;
    logic [2:0]  verdict;
    logic [9:0]  status_code;
    logic [10:0] location_length;
    logic        run_end;

    modport source (
        output valid, output item_kind, output out_byte, output verdict,
        output status_code, output location_length, output run_end, input ready
    );
    modport sink (
        input valid, input item_kind, input out_byte, input verdict,
        input status_code, input location_length, input run_end, output ready
    );
endinterface

`default_nettype wire

@@ hdl/hrhp_front.sv @@
// Parser front end: takes one byte a beat and builds the result bundle for it.
`timescale 1ns / 1ps
`default_nettype none

module hrhp_front
    import hrhp_pkg::*;
#(
    parameter int LOCATION_MAX = 2047,
    parameter int LOC_W        = 11
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    hrhp_in_if.sink               i_in,
    input  wire logic             i_queue_full,
    output      logic             o_push,
    output      t_bundle          o_bundle,
    output      logic [LOC_W-1:0] o_loclen
);

    typedef enum logic [3:0] {
        PH_PREFIX  = 4'd0,
        PH_VERSION = 4'd1,
        PH_GAP     = 4'd2,
        PH_STATUS  = 4'd3,
        PH_REST    = 4'd4,
        PH_BAD     = 4'd5,
        PH_HDR_OK  = 4'd6,
        PH_HDR_LOC = 4'd7,
        PH_LOC_VAL = 4'd8,
        PH_BODY    = 4'd9,
        PH_DONE    = 4'd10
    } t_phase;

    localparam logic [LOC_W-1:0] LOC_LIMIT = LOC_W'(LOCATION_MAX);

    t_phase           r_phase, n_phase;
    logic [3:0]       r_match, n_match;
    logic             r_prev_cr, n_prev_cr;
    logic [9:0]       r_acc, n_acc;
    logic             r_status_seen, n_status_seen;
    logic             r_ver_digit, n_ver_digit;
    logic             r_ver_dot, n_ver_dot;
    logic             r_line_content, n_line_content;
    logic [LOC_W-1:0] r_loc_cnt, n_loc_cnt;
    logic             r_held_cr, n_held_cr;
    logic [2:0]       r_outcome, n_outcome;

    logic             accept;
    logic [7:0]       b;
    logic [7:0]       lower;
    logic             is_dig;
    logic             is_sp;
    logic [13:0]      acc_next;
    logic [LOC_W-1:0] cnt_after_cr;
    logic             cr_emit;
    logic             byte_emit;
    t_bundle          bnd;

    assign i_in.ready = !i_queue_full;
    assign accept     = i_in.valid && !i_queue_full;
    assign b          = i_in.data_byte;

    // Character classes and the status digit step
    assign is_dig   = (b >= CH_ZERO) && (b <= CH_NINE);
    assign is_sp    = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    assign lower    = ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) ? (b + 8'd32) : b;
    assign acc_next = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {10'd0, b[3:0]};

    // Location byte accounting: a held CR may go out ahead of the current byte
    assign cr_emit      = r_held_cr && (r_loc_cnt < LOC_LIMIT);
    assign cnt_after_cr = r_loc_cnt + {{(LOC_W-1){1'b0}}, cr_emit};
    assign byte_emit    = (b != CH_CR) && (cnt_after_cr < LOC_LIMIT);

    // Next state and bundle for the beat on the input
    always_comb begin
        n_phase        = r_phase;
        n_match        = r_match;
        n_prev_cr      = r_prev_cr;
        n_acc          = r_acc;
        n_status_seen  = r_status_seen;
        n_ver_digit    = r_ver_digit;
        n_ver_dot      = r_ver_dot;
        n_line_content = r_line_content;
        n_loc_cnt      = r_loc_cnt;
        n_held_cr      = r_held_cr;
        n_outcome      = r_outcome;
        bnd            = '0;
        o_loclen       = '0;

        case (r_phase)
            PH_PREFIX, PH_VERSION, PH_GAP, PH_STATUS, PH_REST, PH_BAD: begin
                if (b == CH_LF && r_prev_cr) begin
                    // end of the status line
                    if ((r_phase == PH_STATUS || r_phase == PH_REST) && r_status_seen) begin
                        if (r_acc == STATUS_OK) begin
                            n_phase   = PH_HDR_OK;
                            n_outcome = VERD_UNTERMINATED;
                        end else if (r_acc >= STATUS_REDIR_LO && r_acc < STATUS_REDIR_HI) begin
                            n_phase   = PH_HDR_LOC;
                            n_outcome = VERD_NOT_OK;
                        end else begin
                            n_phase   = PH_DONE;
                            n_outcome = VERD_NOT_OK;
                        end
                    end else begin
                        n_phase   = PH_DONE;
                        n_outcome = VERD_MALFORMED;
                    end
                    n_match        = '0;
                    n_prev_cr      = 1'b0;
                    n_line_content = 1'b0;
                end else begin
                    n_prev_cr = (b == CH_CR);
                    case (r_phase)
                        PH_PREFIX: begin
                            if (r_match < PROTO_LEN && b == proto_char(r_match[2:0])) begin
                                n_match = r_match + 4'd1;
                                if (n_match == PROTO_LEN) begin
                                    n_phase = PH_VERSION;
                                end
                            end else begin
                                n_phase = PH_BAD;
                            end
                        end
                        PH_VERSION: begin
                            if (is_dig) begin
                                n_ver_digit = 1'b1;
                            end else if (b == CH_DOT) begin
                                if (r_ver_dot) begin
                                    n_phase = PH_BAD;
                                end
                                n_ver_dot = 1'b1;
                            end else if (is_sp) begin
                                if (r_ver_digit) begin
                                    n_phase = PH_GAP;
                                end else if (r_ver_dot) begin
                                    n_phase = PH_BAD;
                                end
                            end else begin
                                n_phase = PH_BAD;
                            end
                        end
                        PH_GAP: begin
                            if (is_dig) begin
                                n_acc         = {6'd0, b[3:0]};
                                n_status_seen = 1'b1;
                                n_phase       = PH_STATUS;
                            end else if (!is_sp) begin
                                n_phase = PH_BAD;
                            end
                        end
                        PH_STATUS: begin
                            if (is_dig) begin
                                n_acc = (acc_next > {4'd0, STATUS_MAX}) ? STATUS_MAX
                                                                       : acc_next[9:0];
                            end else begin
                                n_phase = PH_REST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            PH_HDR_OK, PH_HDR_LOC: begin
                if (b == CH_LF && r_prev_cr) begin
                    // a header line ends; an empty one closes the headers
                    n_prev_cr      = 1'b0;
                    n_line_content = 1'b0;
                    n_match        = '0;
                    if (!r_line_content) begin
                        if (r_phase == PH_HDR_OK) begin
                            n_phase   = PH_BODY;
                            n_outcome = VERD_BODY_READY;
                        end else begin
                            n_phase   = PH_DONE;
                            n_outcome = VERD_NOT_OK;
                        end
                    end
                end else begin
                    if (r_prev_cr || b != CH_CR) begin
                        n_line_content = 1'b1;
                    end
                    n_prev_cr = (b == CH_CR);
                    if (r_phase == PH_HDR_LOC && r_match < KEY_LEN) begin
                        if (lower == key_char(r_match)) begin
                            n_match = r_match + 4'd1;
                            if (n_match == KEY_LEN) begin
                                n_phase   = PH_LOC_VAL;
                                n_held_cr = 1'b0;
                                n_loc_cnt = '0;
                            end
                        end else begin
                            n_match = MATCH_FAILED;
                        end
                    end
                end
            end
            PH_LOC_VAL: begin
                if (b == CH_LF && r_held_cr) begin
                    n_held_cr = 1'b0;
                    n_phase   = PH_DONE;
                    n_outcome = VERD_REDIRECT;
                end else begin
                    bnd.cr_v      = cr_emit;
                    bnd.byte_v    = byte_emit;
                    bnd.byte_kind = KIND_LOCATION;
                    bnd.data      = b;
                    n_held_cr     = (b == CH_CR);
                    n_loc_cnt     = cnt_after_cr + {{(LOC_W-1){1'b0}}, byte_emit};
                end
            end
            PH_BODY: begin
                bnd.byte_v    = 1'b1;
                bnd.byte_kind = KIND_BODY;
                bnd.data      = b;
            end
            default: begin
            end
        endcase

        // last byte: verdict, then back to the reset state
        if (i_in.last_byte) begin
            bnd.verd_v  = 1'b1;
            bnd.verdict = n_outcome;
            bnd.status  = (n_outcome == VERD_BODY_READY || n_outcome == VERD_REDIRECT ||
                           n_outcome == VERD_NOT_OK) ? n_acc : 10'd0;
            o_loclen    = n_loc_cnt;

            n_phase        = PH_PREFIX;
            n_match        = '0;
            n_prev_cr      = 1'b0;
            n_acc          = '0;
            n_status_seen  = 1'b0;
            n_ver_digit    = 1'b0;
            n_ver_dot      = 1'b0;
            n_line_content = 1'b0;
            n_loc_cnt      = '0;
            n_held_cr      = 1'b0;
            n_outcome      = VERD_NO_STATUS;
        end
    end

    assign o_bundle = bnd;
    assign o_push   = accept && (bnd.cr_v || bnd.byte_v || bnd.verd_v);

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_PREFIX;
            r_match        <= '0;
            r_prev_cr      <= 1'b0;
            r_acc          <= '0;
            r_status_seen  <= 1'b0;
            r_ver_digit    <= 1'b0;
            r_ver_dot      <= 1'b0;
            r_line_content <= 1'b0;
            r_loc_cnt      <= '0;
            r_held_cr      <= 1'b0;
            r_outcome      <= VERD_NO_STATUS;
        end else if (accept) begin
            r_phase        <= n_phase;
            r_match        <= n_match;
            r_prev_cr      <= n_prev_cr;
            r_acc          <= n_acc;
            r_status_seen  <= n_status_seen;
            r_ver_digit    <= n_ver_digit;
            r_ver_dot      <= n_ver_dot;
            r_line_content <= n_line_content;
            r_loc_cnt      <= n_loc_cnt;
            r_held_cr      <= n_held_cr;
            r_outcome      <= n_outcome;
        end
    end

endmodule

`default_nettype wire

@@ hdl/hrhp_queue.sv @@
// Small register queue that decouples the parser from the result sequencer.
`timescale 1ns / 1ps
`default_nettype none

module hrhp_queue
    import hrhp_pkg::*;
#(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output      logic [W-1:0] o_head,
    output      logic         o_full,
    output      logic         o_empty
);

    logic [W-1:0]        r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/hrhp_back.sv @@
// Result sequencer: walks each queued bundle and drives one result beat a cycle while the receiver is ready.
`timescale 1ns / 1ps
`default_nettype none

module hrhp_back
    import hrhp_pkg::*;
#(
    parameter int LOC_W = 11
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_bundle          i_bundle,
    input  wire logic [LOC_W-1:0] i_loclen,
    input  wire logic             i_empty,
    output      logic             o_pop,
    hrhp_out_if.source            o_out
);

    logic             r_valid;
    logic [1:0]       r_kind;
    logic [7:0]       r_byte;
    logic [2:0]       r_verdict;
    logic [9:0]       r_status;
    logic [LOC_W-1:0] r_loclen;
    logic             r_run_end;
    logic             r_cr_done;
    logic             r_byte_done;

    logic             sel_cr;
    logic             sel_byte;
    logic             final_one;
    logic             load;

    // Pick the next result of the head bundle
    assign sel_cr   = i_bundle.cr_v && !r_cr_done;
    assign sel_byte = !sel_cr && i_bundle.byte_v && !r_byte_done;

    always_comb begin
        if (sel_cr) begin
            final_one = !i_bundle.byte_v && !i_bundle.verd_v;
        end else if (sel_byte) begin
            final_one = !i_bundle.verd_v;
        end else begin
            final_one = 1'b1;
        end
    end

    assign load  = !i_empty && (!r_valid || o_out.ready);
    assign o_pop = load && final_one;

    // Output register and progress through the bundle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_cr_done   <= 1'b0;
            r_byte_done <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            if (final_one) begin
                r_cr_done   <= 1'b0;
                r_byte_done <= 1'b0;
            end else if (sel_cr) begin
                r_cr_done <= 1'b1;
            end else begin
                r_byte_done <= 1'b1;
            end
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_run_end <= final_one;
            if (sel_cr) begin
                r_kind    <= KIND_LOCATION;
                r_byte    <= CH_CR;
                r_verdict <= '0;
                r_status  <= '0;
                r_loclen  <= '0;
            end else if (sel_byte) begin
                r_kind    <= i_bundle.byte_kind;
                r_byte    <= i_bundle.data;
                r_verdict <= '0;
                r_status  <= '0;
                r_loclen  <= '0;
            end else begin
                r_kind    <= KIND_VERDICT;
                r_byte    <= '0;
                r_verdict <= i_bundle.verdict;
                r_status  <= i_bundle.status;
                r_loclen  <= i_loclen;
            end
        end
    end

    // location_length is an 11-bit field whatever the counter width
    assign o_out.valid           = r_valid;
    assign o_out.item_kind       = r_kind;
    assign o_out.out_byte        = r_byte;
    assign o_out.verdict         = r_verdict;
    assign o_out.status_code     = r_status;
    assign o_out.location_length = 11'(r_loclen);
    assign o_out.run_end         = r_run_end;

endmodule

`default_nettype wire

@@ hdl/http_reply_header_parser.sv @@
// Top level of the HTTP reply header parser.
//
// i_in carries the raw reply, one byte a beat, with last_byte on the final
// byte. o_out carries results: body bytes for a 200 reply, Location value
// bytes for a 3xx reply, and one verdict beat after the final byte, carrying
// the verdict, the status and the number of location bytes sent. run_end
// marks the last result of each input beat.
// The parser takes one byte every cycle while its four-entry bundle queue has
// room. A byte yields at most three results (a held CR, the byte, a verdict);
// the sequencer drives one result per cycle while the receiver is ready,
// which is one byte per cycle unless bytes carry several results. Results
// go from the queue into the output register before they appear on o_out.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and i_in.ready drops once the queue is full.
// Reset (synchronous, active low) returns the parser to the start of a reply
// and empties the queue and the output register; no clearing pass is needed.
// After the verdict of one reply the parser is ready for the next.
`timescale 1ns / 1ps
`default_nettype none

module http_reply_header_parser
    import hrhp_pkg::*;
#(
    parameter int LOCATION_MAX = 2047
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hrhp_in_if.sink    i_in,
    hrhp_out_if.source o_out
);

    localparam int LOC_W = $clog2(LOCATION_MAX + 1);
    localparam int QW    = $bits(t_bundle) + LOC_W;

    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    t_bundle          bundle_in;
    t_bundle          bundle_head;
    logic [LOC_W-1:0] loclen_in;
    logic [LOC_W-1:0] loclen_head;
    logic [QW-1:0]    head_word;

    // Front end: parse and classify each byte
    hrhp_front #(
        .LOCATION_MAX (LOCATION_MAX),
        .LOC_W        (LOC_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_queue_full (full),
        .o_push       (push),
        .o_bundle     (bundle_in),
        .o_loclen     (loclen_in)
    );

    // Bundle queue
    hrhp_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({bundle_in, loclen_in}),
        .i_pop   (pop),
        .o_head  (head_word),
        .o_full  (full),
        .o_empty (empty)
    );

    assign bundle_head = head_word[QW-1:LOC_W];
    assign loclen_head = head_word[LOC_W-1:0];

    // Back end: one result beat per cycle while the receiver is ready
    hrhp_back #(
        .LOC_W (LOC_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bundle (bundle_head),
        .i_loclen (loclen_head),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire
